/* hdl/modular_exponentiation_defines.svh */
// Assertion macros for the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MODEXP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/modexp_pkg.sv */
// Shared constants for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

    // Width of each input field on the ports.
    localparam int FIELD_W = 32;
    // Width of the result field on the ports.
    localparam int RES_W = 31;

endpackage

`default_nettype wire

/* hdl/modexp_mulmod.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none

module modexp_mulmod #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-2:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-2:0] i_m,
    output logic         o_done,
    output logic [W-2:0] o_r
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-2:0]  r_a;
    logic [W-2:0]  r_m;
    logic [W-1:0]  r_b;
    logic [W-2:0]  r_r;

    logic [W:0]    w_dbl;
    logic [W:0]    w_add;
    logic [W:0]    w_sum;
    logic [W:0]    w_m1;
    logic [W:0]    w_m2;
    logic [W:0]    n_r;

    // With r below m and a at most m, 2r + a stays below 3m, so at most
    // two subtractions of m bring it back into range.
    assign w_dbl = {1'b0, r_r, 1'b0};
    assign w_add = r_b[W-1] ? {2'b00, r_a} : '0;
    assign w_sum = w_dbl + w_add;
    assign w_m1  = {2'b00, r_m};
    assign w_m2  = {1'b0, r_m, 1'b0};

    always_comb begin
        if (w_sum >= w_m2) begin
            n_r = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            n_r = w_sum - w_m1;
        end else begin
            n_r = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_m <= i_m;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r[W-2:0];
            r_b <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

`default_nettype wire

/* hdl/modular_exponentiation.sv */
// An error transaction gives its result in the cycle after acceptance. Otherwise the
// block runs L + 1 modular multiplies, L the bit length of the exponent; each one is
// launched through a start register, runs the bit-serial multiplier one multiplier bit
// at a time, and its result is taken once both multiplier units report done.
// One transaction at a time: busy stays high until the result strobe, and the receiver
// cannot stall. Reset is synchronous, active low, and returns the block to idle.
`default_nettype none

module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [modexp_pkg::FIELD_W-1:0] i_base,
    input  logic signed [modexp_pkg::FIELD_W-1:0] i_exponent,
    input  logic signed [modexp_pkg::FIELD_W-1:0] i_modulus,
    output logic                                 o_valid,
    output logic [modexp_pkg::RES_W-1:0]         o_result,
    output logic                                 o_error
);

    import modexp_pkg::*;

    localparam int VW = WIDTH - 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_MUL    = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic               r_go, n_go;
    logic [VW-1:0]      r_e, n_e;
    logic [VW-1:0]      r_m, n_m;
    logic               r_bneg, n_bneg;
    logic [WIDTH-1:0]   r_bmag, n_bmag;
    logic [VW-1:0]      r_acc, n_acc;
    logic [VW-1:0]      r_base, n_base;
    logic               r_valid, n_valid;
    logic [RES_W-1:0]   r_result, n_result;
    logic               r_error, n_error;

    logic [WIDTH-1:0]   w_base_v;
    logic [WIDTH-1:0]   w_exp_v;
    logic [WIDTH-1:0]   w_mod_v;
    logic [WIDTH-1:0]   w_bmag;
    logic               w_err;
    logic [VW-1:0]      w_a0;
    logic [WIDTH-1:0]   w_b0;
    logic [VW-1:0]      w_r0;
    logic [VW-1:0]      w_r1;
    logic               w_done0;
    logic               w_done1;
    logic               w_done;
    logic [VW-1:0]      w_fix;
    logic [VW-1:0]      w_one;
    logic [VW-1:0]      w_acc_mul;
    logic [VW-1:0]      w_e_sh;

    // Each field is read as a WIDTH-bit two's complement value.
    assign w_base_v = WIDTH'(i_base);
    assign w_exp_v  = WIDTH'(i_exponent);
    assign w_mod_v  = WIDTH'(i_modulus);
    assign w_bmag   = w_base_v[WIDTH-1] ? (~w_base_v + WIDTH'(1)) : w_base_v;
    assign w_err    = w_exp_v[WIDTH-1] | w_mod_v[WIDTH-1] | (w_mod_v == '0);

    // Unit 0 first reduces the base (1 * |base| mod m), then multiplies the
    // accumulator; unit 1 squares the base alongside it.
    assign w_a0 = (r_state == S_REDUCE) ? VW'(1) : r_acc;
    assign w_b0 = (r_state == S_REDUCE) ? r_bmag : {1'b0, r_base};

    modexp_mulmod #(.W(WIDTH)) u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (w_a0),
        .i_b     (w_b0),
        .i_m     (r_m),
        .o_done  (w_done0),
        .o_r     (w_r0)
    );

    modexp_mulmod #(.W(WIDTH)) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (r_base),
        .i_b     ({1'b0, r_base}),
        .i_m     (r_m),
        .o_done  (w_done1),
        .o_r     (w_r1)
    );

    assign w_done    = w_done0 & w_done1;
    // Floor modulo of a negative base: a nonzero remainder is flipped to m - r.
    assign w_fix     = (r_bneg && (w_r0 != '0)) ? (r_m - w_r0) : w_r0;
    assign w_one     = (r_m == VW'(1)) ? '0 : VW'(1);
    assign w_acc_mul = r_e[0] ? w_r0 : r_acc;
    assign w_e_sh    = r_e >> 1;

    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        n_e      = r_e;
        n_m      = r_m;
        n_bneg   = r_bneg;
        n_bmag   = r_bmag;
        n_acc    = r_acc;
        n_base   = r_base;
        n_valid  = 1'b0;
        n_result = r_result;
        n_error  = r_error;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_err) begin
                        n_valid  = 1'b1;
                        n_result = '0;
                        n_error  = 1'b1;
                    end else begin
                        n_state = S_REDUCE;
                        n_go    = 1'b1;
                        n_e     = w_exp_v[VW-1:0];
                        n_m     = w_mod_v[VW-1:0];
                        n_bneg  = w_base_v[WIDTH-1];
                        n_bmag  = w_bmag;
                    end
                end
            end
            S_REDUCE: begin
                if (w_done) begin
                    n_base = w_fix;
                    n_acc  = w_one;
                    if (r_e == '0) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_result = RES_W'(w_one);
                        n_error  = 1'b0;
                    end else begin
                        n_state = S_MUL;
                        n_go    = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (w_done) begin
                    n_acc  = w_acc_mul;
                    n_base = w_r1;
                    n_e    = w_e_sh;
                    if (w_e_sh == '0) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_result = RES_W'(w_acc_mul);
                        n_error  = 1'b0;
                    end else begin
                        n_go = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e      <= n_e;
        r_m      <= n_m;
        r_bneg   <= n_bneg;
        r_bmag   <= n_bmag;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_result <= n_result;
        r_error  <= n_error;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_error  = r_error;

endmodule

`default_nettype wire

/* hdl/modexp_checker.sv */
// Port-level checker for the modular exponentiation block, with its bind.
`default_nettype none

`include "modular_exponentiation_defines.svh"

module modexp_props (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 start,
    input wire                                 busy,
    input wire signed [modexp_pkg::FIELD_W-1:0] i_modulus,
    input wire                                 o_valid,
    input wire [modexp_pkg::RES_W-1:0]         o_result,
    input wire                                 o_error
);

    import modexp_pkg::*;

    // An error transaction always reports a zero result.
    `MODEXP_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_valid && o_error,
        o_result == '0, "error result is not zero")

    // A zero modulus is reported as an error in the very next cycle.
    `MODEXP_ASSERT_NEXT(a_zero_mod, i_clk, i_rst_n, start && !busy && (i_modulus == '0),
        o_valid && o_error, "zero modulus not flagged")

    // A computed result only appears as the block leaves its busy phase.
    `MODEXP_ASSERT_SAME(a_ok_after_busy, i_clk, i_rst_n, o_valid && !o_error,
        $past(busy) && !busy, "result without busy phase")

    // Busy never drops without delivering the result.
    `MODEXP_ASSERT_SAME(a_busy_fall, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n),
        o_valid && !o_error, "busy fell without result")

endmodule

bind modular_exponentiation modexp_props u_modexp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_modulus (i_modulus),
    .o_valid   (o_valid),
    .o_result  (o_result),
    .o_error   (o_error)
);

`default_nettype wire
